// File: sv/lkps_pkg.sv
package lkps_pkg;

   localparam int TIME_W      = 32;
   localparam int WORD_W      = 32;
   localparam int COUNT_W     = 5;
   localparam int SLOT_W      = 4;
   localparam int FUNC_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int SUM_W       = TIME_W + 1;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 1;

   localparam int MAX_POINTS_DEFAULT = 16;

   localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT    = 1'b1;

endpackage

// File: sv/lkps_ram.sv
module lkps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/led_keyframe_pattern_sequencer.sv
// Restart, table write and non-advancing update go from accept to ST_OUT_RD, ST_OUT_LOAD.
// Advancing update: ST_SUM, then ST_MOD when the loop wraps (bit-serial remainder), then
// the forward and backward walks (read and check states), then ST_OUT_RD and ST_OUT_LOAD.
// Throughput: one item at a time; req_tready is high only in idle, the cycle after the
// result is loaded, and a result still held by rsp_tready low delays that load.
// Reset: synchronous, active high; clears FSM, CSRs, valid, stamp, elapsed, idx; RAM kept.
module led_keyframe_pattern_sequencer #(
   parameter int MAX_POINTS = lkps_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // now_ms, entry_index, entry_ms, entry_output, zero pad
   input  logic [lkps_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // func
   input  logic [lkps_pkg::FUNC_W-1:0]          req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // point_output, current_point, zero pad
   output logic [lkps_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // output_valid
   output logic [lkps_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input  logic                                 csr_we,
   input  logic [lkps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lkps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int TW     = lkps_pkg::TIME_W;
   localparam int WW     = lkps_pkg::WORD_W;
   localparam int CW     = lkps_pkg::COUNT_W;
   localparam int SW     = lkps_pkg::SUM_W;
   localparam int BCNT_W = $clog2(SW);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_MOD,
      ST_FWD_RD,
      ST_FWD_CHK,
      ST_BWD_RD,
      ST_BWD_CHK,
      ST_OUT_RD,
      ST_OUT_LOAD
   } state_type;

   state_type            state_ff;
   logic [TW-1:0]        duration_ff;
   logic [CW-1:0]        point_count_ff;
   logic [TW-1:0]        last_stamp_ff;
   logic [TW-1:0]        elapsed_ff;
   logic [CW-1:0]        idx_ff;
   logic [TW-1:0]        delta_ff;
   logic [SW-1:0]        sum_ff;
   logic [TW-1:0]        rem_ff;
   logic [BCNT_W-1:0]    bit_cnt_ff;
   logic [CW-1:0]        out_idx_ff;
   logic                 rsp_valid_ff;
   logic [WW-1:0]        rsp_word_ff;
   logic [lkps_pkg::SLOT_W-1:0] rsp_point_ff;
   logic                 rsp_flag_ff;

   logic [TW-1:0]        req_now;
   logic [lkps_pkg::SLOT_W-1:0] req_slot;
   logic [TW-1:0]        req_ems;
   logic [WW-1:0]        req_eout;

   logic [CW-1:0]        count;
   logic [TW-1:0]        delta_in;
   logic [SW-1:0]        sum_in;
   logic [SW-1:0]        trial;
   logic                 trial_ge;
   logic [CW-1:0]        idx_next;
   logic [CW-1:0]        out_idx_in;
   logic                 accept;

   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [TW+WW-1:0]     ram_rd_data;
   logic [TW-1:0]        rd_time;
   logic [WW-1:0]        rd_word;

   assign req_now  = req_tdata[31:0];
   assign req_slot = req_tdata[35:32];
   assign req_ems  = req_tdata[67:36];
   assign req_eout = req_tdata[99:68];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign count = (32'(point_count_ff) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : point_count_ff;

   assign delta_in = (req_now >= last_stamp_ff) ? (req_now - last_stamp_ff) : '0;
   assign sum_in   = {1'b0, elapsed_ff} + {1'b0, delta_ff};
   assign trial    = {rem_ff, sum_ff[SW-1]};
   assign trial_ge = (trial >= {1'b0, duration_ff});
   assign idx_next = idx_ff + CW'(1);

   assign out_idx_in = (count == '0 || idx_ff >= count) ? '0 : idx_ff;

   assign ram_wr_en = accept && (req_tuser == lkps_pkg::FUNC_WRITE)
                      && (32'(req_slot) < 32'(MAX_POINTS));

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(idx_ff);
      unique case (state_ff)
         ST_FWD_RD: begin
            ram_rd_en   = (idx_next < count);
            ram_rd_addr = AW'(idx_next);
         end
         ST_BWD_RD: begin
            ram_rd_en   = (idx_ff != '0);
            ram_rd_addr = AW'(idx_ff);
         end
         ST_OUT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(out_idx_in);
         end
         default: begin
            ram_rd_en   = 1'b0;
            ram_rd_addr = AW'(idx_ff);
         end
      endcase
   end

   lkps_ram #(
      .WIDTH (TW + WW),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_slot)),
      .wr_data ({req_eout, req_ems}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_time = ram_rd_data[TW-1:0];
   assign rd_word = ram_rd_data[TW+WW-1:TW];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         duration_ff    <= '0;
         point_count_ff <= '0;
         last_stamp_ff  <= '0;
         elapsed_ff     <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               lkps_pkg::CSR_DURATION: duration_ff    <= csr_wdata[TW-1:0];
               lkps_pkg::CSR_COUNT:    point_count_ff <= csr_wdata[CW-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUT_LOAD) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= (req_tuser == lkps_pkg::FUNC_UPDATE && delta_in != '0
                               && count != '0 && duration_ff != '0) ? ST_SUM : ST_OUT_RD;
                  case (req_tuser)
                     lkps_pkg::FUNC_UPDATE: begin
                        last_stamp_ff <= req_now;
                        delta_ff      <= delta_in;
                        if (delta_in != '0) begin
                           if (count == '0 || duration_ff == '0) begin
                              elapsed_ff <= '0;
                              idx_ff     <= '0;
                           end else if (idx_ff >= count) begin
                              idx_ff <= count - CW'(1);
                           end
                        end
                     end
                     lkps_pkg::FUNC_RESTART: begin
                        last_stamp_ff <= req_now;
                        elapsed_ff    <= '0;
                        idx_ff        <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SUM: begin
               if (sum_in >= {1'b0, duration_ff}) begin
                  sum_ff     <= sum_in;
                  rem_ff     <= '0;
                  bit_cnt_ff <= '0;
                  idx_ff     <= '0;
                  state_ff   <= ST_MOD;
               end else begin
                  elapsed_ff <= sum_in[TW-1:0];
                  state_ff   <= ST_FWD_RD;
               end
            end
            ST_MOD: begin
               // one remainder bit per cycle, MSB of the sum first
               rem_ff     <= trial_ge ? TW'(trial - {1'b0, duration_ff}) : trial[TW-1:0];
               sum_ff     <= {sum_ff[SW-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff + BCNT_W'(1);
               if (bit_cnt_ff == BCNT_W'(SW - 1)) begin
                  elapsed_ff <= trial_ge ? TW'(trial - {1'b0, duration_ff}) : trial[TW-1:0];
                  state_ff   <= ST_FWD_RD;
               end
            end
            ST_FWD_RD: begin
               state_ff <= (idx_next < count) ? ST_FWD_CHK : ST_BWD_RD;
            end
            ST_FWD_CHK: begin
               if (rd_time <= elapsed_ff) begin
                  idx_ff   <= idx_next;
                  state_ff <= ST_FWD_RD;
               end else begin
                  state_ff <= ST_BWD_RD;
               end
            end
            ST_BWD_RD: begin
               state_ff <= (idx_ff != '0) ? ST_BWD_CHK : ST_OUT_RD;
            end
            ST_BWD_CHK: begin
               if (rd_time > elapsed_ff) begin
                  idx_ff   <= idx_ff - CW'(1);
                  state_ff <= ST_BWD_RD;
               end else begin
                  state_ff <= ST_OUT_RD;
               end
            end
            ST_OUT_RD: begin
               out_idx_ff <= out_idx_in;
               state_ff   <= ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_flag_ff  <= (count != '0);
                  rsp_word_ff  <= (count != '0) ? rd_word : '0;
                  rsp_point_ff <= (count != '0) ? out_idx_ff[lkps_pkg::SLOT_W-1:0] : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lkps_pkg::RSP_TDATA_W - lkps_pkg::SLOT_W - WW){1'b0}},
                        rsp_point_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_flag_ff;

endmodule

// File: sv/lkps_checker.sv
module lkps_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [lkps_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [lkps_pkg::FUNC_W-1:0]          req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [lkps_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic [lkps_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input  logic                                 csr_we,
   input  logic [lkps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lkps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // held result does not change while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // no point in use: result word and index are zero
   a_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("rsp data nonzero with output_valid low");

   // one item at a time: no accept right after an accept
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted in back-to-back cycles");

   // no result shows up in the first cycle after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

endmodule

bind led_keyframe_pattern_sequencer lkps_checker u_lkps_checker (.*);
